// ===== rtl/rps_pkg.sv =====
package rps_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    // Segment classes
    localparam logic [1:0] CLS_EMPTY  = 2'd0;
    localparam logic [1:0] CLS_DOT    = 2'd1;
    localparam logic [1:0] CLS_DOTDOT = 2'd2;
    localparam logic [1:0] CLS_PLAIN  = 2'd3;

    localparam logic [7:0] CH_SLASH     = 8'h2f;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_COLON     = 8'h3a;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_DOT       = 8'h2e;

    typedef struct packed {
        logic [7:0] in_char;
        logic       char_present;
        logic       path_last;
    } rps_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_valid;
        logic       path_done;
        logic       rejected;
    } rps_result_t;

    typedef struct packed {
        rps_result_t [MAX_RESULTS-1:0] res;
        logic [CNT_W-1:0]              cnt;
    } rps_burst_t;

endpackage

// ===== rtl/relative_path_sanitizer.sv =====
// Relative path sanitizer: takes a path one character per request and returns its
// canonical form with '/' between segments, followed by one end result (tlast)
// whose rejected bit tells the consumer to discard the characters of that path.
// A request passes an input register, the classification logic and a result
// buffer, so the first result of a request is offered on the result side when the
// input register has handed it on and the buffer has loaded it. The block takes
// one request per cycle while each causes at most one result and m_tready is high;
// a request that causes k results (up to five: separator, two held dots, the
// character and the end) holds the buffer until all k are taken, as it hands
// out one result per cycle while m_tready is high, and a following request that
// causes results waits until the buffer drains. Requests that cause no result pass
// through without waiting. No clearing pass is needed after reset.
module relative_path_sanitizer
    import rps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_char
    input  logic       s_tlast,   // path_last
    input  logic       s_tuser,   // char_present
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_char
    output logic       m_tlast,   // path_done
    output logic [1:0] m_tuser    // out_valid, rejected
);

    rps_item_t  item;
    logic       item_vld;
    rps_burst_t burst;
    logic       free_next;
    logic       adv;
    logic       load;

    assign adv  = item_vld && ((burst.cnt == '0) || free_next);
    assign load = adv && (burst.cnt != '0);

    rps_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .adv      (adv),
        .item_vld (item_vld),
        .item     (item)
    );

    rps_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .step  (adv),
        .burst (burst)
    );

    rps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .burst     (burst),
        .free_next (free_next),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/rps_in_reg.sv =====
module rps_in_reg
    import rps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_char
    input  logic       s_tlast,   // path_last
    input  logic       s_tuser,   // char_present
    input  logic       adv,
    output logic       item_vld,
    output rps_item_t  item
);

    logic      vld_reg;
    logic      vld_next;
    rps_item_t item_reg;
    logic      accept;

    assign s_tready = !vld_reg || adv;
    assign accept   = s_tvalid && s_tready;
    assign item_vld = vld_reg;
    assign item     = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (adv)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.in_char      <= s_tdata;
            item_reg.char_present <= s_tuser;
            item_reg.path_last    <= s_tlast;
        end
    end

endmodule

// ===== rtl/rps_core.sv =====
module rps_core
    import rps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rps_item_t  item,
    input  logic       step,
    output rps_burst_t burst
);

    logic       first_reg, first_next;
    logic [1:0] cls_reg, cls_next;
    logic       any_reg, any_next;
    logic       rej_reg, rej_next;

    logic       open_seg;
    logic [1:0] dots;
    logic       put_c;
    logic       is_sep;
    logic       is_bad;
    logic       is_dot;
    logic [CNT_W-1:0] n;
    rps_result_t r_slash, r_dot, r_char, r_end;

    assign is_sep = (item.in_char == CH_SLASH) || (item.in_char == CH_BACKSLASH);
    assign is_bad = (item.in_char == CH_NUL) || (item.in_char == CH_COLON);
    assign is_dot = (item.in_char == CH_DOT);

    always_comb
    begin
        first_next = first_reg;
        cls_next   = cls_reg;
        any_next   = any_reg;
        rej_next   = rej_reg;
        open_seg   = 1'b0;
        dots       = 2'd0;
        put_c      = 1'b0;

        if (item.char_present && !rej_reg)
        begin
            first_next = 1'b0;
            if (is_sep)
            begin
                if (first_reg || cls_reg == CLS_DOTDOT)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    cls_next = CLS_EMPTY;
                end
            end
            else if (is_bad)
            begin
                rej_next = 1'b1;
            end
            else
            begin
                case (cls_reg)
                    CLS_EMPTY:
                    begin
                        if (is_dot)
                        begin
                            cls_next = CLS_DOT;
                        end
                        else
                        begin
                            open_seg = 1'b1;
                        end
                    end
                    CLS_DOT:
                    begin
                        if (is_dot)
                        begin
                            cls_next = CLS_DOTDOT;
                        end
                        else
                        begin
                            open_seg = 1'b1;
                            dots     = 2'd1;
                        end
                    end
                    CLS_DOTDOT:
                    begin
                        open_seg = 1'b1;
                        dots     = 2'd2;
                    end
                    default:
                    begin
                        put_c = 1'b1;
                    end
                endcase
            end
        end
        else if (item.char_present)
        begin
            first_next = 1'b0;
        end

        if (open_seg)
        begin
            any_next = 1'b1;
            cls_next = CLS_PLAIN;
            put_c    = 1'b1;
        end

        // A path that ends on ".." or that never produced a segment is invalid.
        if (item.path_last && !rej_next)
        begin
            if (cls_next == CLS_DOTDOT || !any_next)
            begin
                rej_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        r_slash = '{out_char: CH_SLASH, out_valid: 1'b1, path_done: 1'b0, rejected: 1'b0};
        r_dot   = '{out_char: CH_DOT, out_valid: 1'b1, path_done: 1'b0, rejected: 1'b0};
        r_char  = '{out_char: item.in_char, out_valid: 1'b1, path_done: 1'b0,
                    rejected: 1'b0};
        r_end   = '{out_char: 8'h00, out_valid: 1'b0, path_done: 1'b1, rejected: rej_next};

        burst.res = '0;
        n = '0;
        if (open_seg && any_reg)
        begin
            burst.res[n] = r_slash;
            n = n + CNT_W'(1);
        end
        if (dots != 2'd0)
        begin
            burst.res[n] = r_dot;
            n = n + CNT_W'(1);
        end
        if (dots == 2'd2)
        begin
            burst.res[n] = r_dot;
            n = n + CNT_W'(1);
        end
        if (put_c)
        begin
            burst.res[n] = r_char;
            n = n + CNT_W'(1);
        end
        if (item.path_last)
        begin
            burst.res[n] = r_end;
            n = n + CNT_W'(1);
        end
        burst.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            cls_reg   <= CLS_EMPTY;
            any_reg   <= 1'b0;
            rej_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (item.path_last)
            begin
                first_reg <= 1'b1;
                cls_reg   <= CLS_EMPTY;
                any_reg   <= 1'b0;
                rej_reg   <= 1'b0;
            end
            else
            begin
                first_reg <= first_next;
                cls_reg   <= cls_next;
                any_reg   <= any_next;
                rej_reg   <= rej_next;
            end
        end
    end

endmodule

// ===== rtl/rps_out_buf.sv =====
module rps_out_buf
    import rps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  rps_burst_t  burst,
    output logic        free_next,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char
    output logic        m_tlast,   // path_done
    output logic [1:0]  m_tuser    // out_valid, rejected
);

    rps_result_t [MAX_RESULTS-1:0] ent_reg;
    rps_result_t [MAX_RESULTS-1:0] ent_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic                          take;

    assign m_tvalid  = (cnt_reg != '0);
    assign take      = m_tvalid && m_tready;
    assign free_next = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_tready);
    assign m_tdata   = ent_reg[0].out_char;
    assign m_tlast   = ent_reg[0].path_done;
    assign m_tuser   = {ent_reg[0].rejected, ent_reg[0].out_valid};

    always_comb
    begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            ent_next = burst.res;
            cnt_next = burst.cnt;
        end
        else if (take)
        begin
            // The head result leaves; the rest move down one place.
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                ent_next[i] = ent_reg[i+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

// ===== rtl/rps_checker.sv =====
module rps_checker
    import rps_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // A stalled result request holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    // The end result carries no character.
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tuser[0] && (m_tdata == 8'h00))
        else $error("end result carries a character");

    // Character results are never flagged as rejected.
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser[0] && !m_tuser[1])
        else $error("character result malformed");

    // Backslash, colon and NUL never reach the output.
    a_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata != CH_BACKSLASH) && (m_tdata != CH_COLON)
            && (m_tdata != CH_NUL))
        else $error("forbidden character emitted");

endmodule

bind relative_path_sanitizer rps_checker u_rps_checker (.*);

// ===== verif/testbench.sv =====
module testbench;
    import rps_pkg::*;

    typedef enum logic [1:0] {
        FROM_MODEL,
        END_ACCEPTS,
        END_REJECTS
    } end_check_e;

    typedef struct {
        logic [7:0] ch;
        logic       present;
        logic       last;
        end_check_e want;
    } step_row_t;

    localparam int NUM_DIRECTED = 25;
    localparam int NUM_ITEMS    = 525;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // in_char
    logic       s_tlast = 1'b0;    // path_last
    logic       s_tuser = 1'b0;    // char_present
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // out_char
    logic       m_tlast;           // path_done
    logic [1:0] m_tuser;           // out_valid, rejected

    // Mirror of the sanitizer state.
    logic       at_path_start = 1'b1;
    logic [1:0] seg_kind = CLS_EMPTY;
    logic       seg_seen = 1'b0;
    logic       path_bad = 1'b0;

    rps_result_t canon_results[$];
    step_row_t   directed_rows[NUM_DIRECTED];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          ready_mode = 0;
    int          mode_left = 0;
    int          stall_left = 0;

    relative_path_sanitizer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic emit_char(input logic [7:0] ch);
        rps_result_t r;
        r.out_char  = ch;
        r.out_valid = 1'b1;
        r.path_done = 1'b0;
        r.rejected  = 1'b0;
        canon_results = {canon_results, r};
    endtask

    // A segment becomes certain: separator first if one came before, then held dots.
    task automatic start_segment(input int held_dots);
        if (seg_seen)
            emit_char(CH_SLASH);
        for (int i = 0; i < held_dots; i++)
            emit_char(CH_DOT);
        seg_seen = 1'b1;
        seg_kind = CLS_PLAIN;
    endtask

    task automatic sanitize_step(input logic [7:0] ch, input logic present, input logic last,
                                 input end_check_e want);
        logic        first;
        rps_result_t fin;
        if (present && !path_bad)
        begin
            first = at_path_start;
            at_path_start = 1'b0;
            if (ch == CH_SLASH || ch == CH_BACKSLASH)
            begin
                if (first || seg_kind == CLS_DOTDOT)
                    path_bad = 1'b1;
                else
                    seg_kind = CLS_EMPTY;
            end
            else if (ch == CH_NUL || ch == CH_COLON)
                path_bad = 1'b1;
            else
            begin
                case (seg_kind)
                    CLS_EMPTY:
                        if (ch == CH_DOT)
                            seg_kind = CLS_DOT;
                        else
                        begin
                            start_segment(0);
                            emit_char(ch);
                        end
                    CLS_DOT:
                        if (ch == CH_DOT)
                            seg_kind = CLS_DOTDOT;
                        else
                        begin
                            start_segment(1);
                            emit_char(ch);
                        end
                    CLS_DOTDOT:
                    begin
                        start_segment(2);
                        emit_char(ch);
                    end
                    default:
                        emit_char(ch);
                endcase
            end
        end
        else if (present)
            at_path_start = 1'b0;

        if (last)
        begin
            if (!path_bad && (seg_kind == CLS_DOTDOT || !seg_seen))
                path_bad = 1'b1;
            fin.out_char  = 8'h00;
            fin.out_valid = 1'b0;
            fin.path_done = 1'b1;
            fin.rejected  = path_bad;
            if (want != FROM_MODEL)
                fin.rejected = (want == END_REJECTS);
            canon_results = {canon_results, fin};
            at_path_start = 1'b1;
            seg_kind = CLS_EMPTY;
            seg_seen = 1'b0;
            path_bad = 1'b0;
        end
    endtask

    task automatic send_request(input logic [7:0] ch, input logic present, input logic last,
                                input end_check_e want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= present;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sanitize_step(ch, present, last, want);
        if (present || last)
            items_sent++;
    endtask

    // Hold off the sender until every pending result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (canon_results.size() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    function automatic logic [7:0] pick_seg_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 78)
            return CH_DOT;
        else if (r < 90)
            return 8'($urandom_range(0, 255));
        else
            return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_sep();
        return $urandom_range(0, 1) ? CH_SLASH : CH_BACKSLASH;
    endfunction

    task automatic send_random_path();
        logic [7:0] chars[$];
        int         nseg;
        int         n;
        int         r;
        logic       end_on_char;
        // Noise: every field random, the last request closes the path.
        if ($urandom_range(0, 6) == 0)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             (i == n - 1) ? 1'b1 : 1'($urandom_range(0, 1)), FROM_MODEL);
            return;
        end
        if ($urandom_range(0, 9) == 0)
            chars = {chars, pick_sep()};
        nseg = $urandom_range(0, 4);
        for (int s = 0; s < nseg; s++)
        begin
            if (s > 0)
            begin
                chars = {chars, pick_sep()};
                if ($urandom_range(0, 6) == 0)
                    chars = {chars, pick_sep()};
            end
            r = $urandom_range(0, 19);
            if (r < 2)
                chars = {chars, CH_DOT};
            else if (r < 4)
            begin
                chars = {chars, CH_DOT};
                chars = {chars, CH_DOT};
            end
            else if (r < 5)
            begin
                n = $urandom_range(3, 4);
                for (int i = 0; i < n; i++)
                    chars = {chars, CH_DOT};
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    chars = {chars, pick_seg_char()};
            end
        end
        if ($urandom_range(0, 6) == 0)
            chars = {chars, pick_sep()};

        end_on_char = (chars.size() > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < chars.size(); i++)
        begin
            send_request(chars[i], 1'b1, end_on_char && (i == chars.size() - 1), FROM_MODEL);
            if ($urandom_range(0, 9) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, FROM_MODEL);
        end
        if (!end_on_char)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, FROM_MODEL);
    endtask

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result side: check accepted results, then pick the next ready level.
    always @(posedge clk)
    begin
        rps_result_t want;
        logic        nxt;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (canon_results.size() == 0)
            begin
                $error("unexpected result: out_char %0h, out_valid %0b, path_done %0b",
                       m_tdata, m_tuser[0], m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = canon_results.pop_front();
                compare_field("out_char", want.out_char, m_tdata);
                compare_field("out_valid", 8'(want.out_valid), 8'(m_tuser[0]));
                compare_field("path_done", 8'(want.path_done), 8'(m_tlast));
                compare_field("rejected", 8'(want.rejected), 8'(m_tuser[1]));
            end
        end

        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (ready_mode)
            0: nxt = 1'b1;
            1: nxt = ($urandom_range(0, 3) != 0);
            2: nxt = ~m_tready;
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    nxt = 1'b0;
                end
                else
                begin
                    nxt = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 12);
                end
            end
        endcase
        m_tready <= nxt;
    end

    initial
    begin
        bit mid_drain_done;
        mid_drain_done = 1'b0;

        directed_rows = '{
            '{CH_SLASH,     1'b1, 1'b1, END_REJECTS},  // leading separator
            '{CH_NUL,       1'b0, 1'b1, END_REJECTS},  // empty path
            '{CH_NUL,       1'b0, 1'b0, FROM_MODEL},   // empty request, no effect
            '{"a",          1'b1, 1'b0, FROM_MODEL},
            '{CH_BACKSLASH, 1'b1, 1'b0, FROM_MODEL},
            '{CH_DOT,       1'b1, 1'b0, FROM_MODEL},   // single dot segment dropped
            '{CH_SLASH,     1'b1, 1'b0, FROM_MODEL},
            '{8'hff,        1'b1, 1'b0, FROM_MODEL},
            '{CH_SLASH,     1'b1, 1'b0, FROM_MODEL},
            '{CH_DOT,       1'b1, 1'b0, FROM_MODEL},
            '{CH_DOT,       1'b1, 1'b0, FROM_MODEL},
            '{"x",          1'b1, 1'b1, END_ACCEPTS},  // separator, two dots, char, end
            '{CH_DOT,       1'b1, 1'b0, FROM_MODEL},
            '{CH_DOT,       1'b1, 1'b0, FROM_MODEL},
            '{CH_SLASH,     1'b1, 1'b1, END_REJECTS},  // parent segment
            '{CH_COLON,     1'b1, 1'b1, END_REJECTS},
            '{CH_NUL,       1'b1, 1'b1, END_REJECTS},
            '{CH_DOT,       1'b1, 1'b0, FROM_MODEL},
            '{CH_DOT,       1'b1, 1'b0, FROM_MODEL},
            '{CH_DOT,       1'b1, 1'b1, END_ACCEPTS},  // three dots are ordinary
            '{8'h41,        1'b0, 1'b0, FROM_MODEL},   // char ignored without present
            '{CH_COLON,     1'b1, 1'b0, FROM_MODEL},
            '{"z",          1'b1, 1'b0, FROM_MODEL},   // swallowed after reject
            '{CH_DOT,       1'b1, 1'b1, END_REJECTS},
            '{CH_DOT,       1'b1, 1'b1, END_REJECTS}   // only a dot segment
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].ch, directed_rows[i].present,
                         directed_rows[i].last, directed_rows[i].want);
        drain_results();

        while (items_sent < NUM_ITEMS)
        begin
            send_random_path();
            if (!mid_drain_done && items_sent >= NUM_DIRECTED + NUM_ITEMS / 2)
            begin
                drain_results();
                mid_drain_done = 1'b1;
            end
            else if ($urandom_range(0, 39) == 0)
                drain_results();
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (canon_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
